[src/tilt_pkg.sv]
// Shared types and constants for the tilt level LED indicator.
// No dependencies.
`default_nettype none
package tilt_pkg;

  localparam int DEG90_Q8 = 23040;

  // controller -> datapath commands
  typedef struct packed {
    logic load;    // latch sample, start filter
    logic filt;    // filter step
    logic cinit;   // prepare CORDIC
    logic citer;   // one CORDIC step
    logic fin;     // finish, compute outputs
  } tilt_cmd_t;

  typedef struct packed {
    logic last_iter;
  } tilt_sts_t;

  // arctangent in degrees Q.16
  function automatic logic [21:0] atan_q16(input logic [4:0] k);
    case (k)
      5'd0: atan_q16 = 22'd2949120;
      5'd1: atan_q16 = 22'd1740967;
      5'd2: atan_q16 = 22'd919879;
      5'd3: atan_q16 = 22'd466945;
      5'd4: atan_q16 = 22'd234379;
      5'd5: atan_q16 = 22'd117304;
      5'd6: atan_q16 = 22'd58666;
      5'd7: atan_q16 = 22'd29335;
      5'd8: atan_q16 = 22'd14668;
      5'd9: atan_q16 = 22'd7334;
      5'd10: atan_q16 = 22'd3667;
      5'd11: atan_q16 = 22'd1833;
      5'd12: atan_q16 = 22'd917;
      5'd13: atan_q16 = 22'd458;
      5'd14: atan_q16 = 22'd229;
      5'd15: atan_q16 = 22'd115;
      5'd16: atan_q16 = 22'd57;
      5'd17: atan_q16 = 22'd29;
      5'd18: atan_q16 = 22'd14;
      5'd19: atan_q16 = 22'd7;
      5'd20: atan_q16 = 22'd4;
      5'd21: atan_q16 = 22'd2;
      5'd22: atan_q16 = 22'd1;
      default: atan_q16 = 22'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

[src/tilt_ctrl.sv]
// Sequencer for the tilt indicator: load, filter, CORDIC loop, finish.
// Depends on tilt_pkg.
`default_nettype none
module tilt_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire tilt_pkg::tilt_sts_t sts,
  output tilt_pkg::tilt_cmd_t   cmd
);
  import tilt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FILT = 3'd1;
  localparam logic [2:0] S_CINIT = 3'd2;
  localparam logic [2:0] S_ITER = 3'd3;
  localparam logic [2:0] S_FIN = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       take;

  // next request accepted only in idle and once the output register is free (or freeing)
  assign in_stall  = (state_r != S_IDLE) || (ovalid_r && out_stall);
  assign take      = in_valid && !in_stall;
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r && out_stall;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          cmd.load  = 1'b1;
          state_nxt = S_FILT;
        end
      end
      S_FILT: begin
        cmd.filt  = 1'b1;
        state_nxt = S_CINIT;
      end
      S_CINIT: begin
        cmd.cinit = 1'b1;
        state_nxt = S_ITER;
      end
      S_ITER: begin
        cmd.citer = 1'b1;
        if (sts.last_iter) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        ovalid_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end
endmodule
`default_nettype wire

[src/tilt_dp.sv]
// Datapath: low-pass filters, shock detector, CORDIC, LED mapping, output register.
// Depends on tilt_pkg.
`default_nettype none
module tilt_dp #(
  parameter int SAMPLE_BITS      = 16,
  parameter int FILTER_FRAC_BITS = 16,
  parameter int CORDIC_STEPS     = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tilt_pkg::tilt_cmd_t cmd,
  output tilt_pkg::tilt_sts_t      sts,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic                cfg_hi,
  input  wire logic [15:0]         cfg_data,
  input  wire logic [15:0]         in_accel_x,
  input  wire logic [15:0]         in_accel_y,
  input  wire logic [15:0]         in_accel_z,
  output logic                     out_in_window,
  output logic [3:0]               out_led_index,
  output logic [2:0]               out_decoder_select,
  output logic                     out_bank_enable,
  output logic [1:0]               out_level_now,
  output logic                     out_level_changed,
  output logic signed [16:0]       out_roll_angle
);
  import tilt_pkg::*;

  localparam int FW = SAMPLE_BITS + FILTER_FRAC_BITS + 1; // filter word
  localparam int CW = FW + 2;                             // CORDIC word
  localparam int KW = $clog2(CORDIC_STEPS + 1);

  logic [15:0] alpha_r, thr_r;
  logic signed [SAMPLE_BITS-1:0] sx_r, sy_r, sz_r;
  logic signed [FW-1:0] fx_r, fy_r, fz_r;
  logic [1:0] level_r;
  logic       changed_r;
  logic signed [CW-1:0] cx_r, cy_r;
  logic signed [26:0]   ang_r;
  logic [KW-1:0]        k_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= 16'd58982;
      thr_r   <= 16'd53444;
    end else if (cfg_we && !cfg_hi) begin
      if (cfg_index) thr_r <= cfg_data;
      else           alpha_r <= cfg_data;
    end
  end

  // shock: squared magnitude against squared threshold
  logic signed [SAMPLE_BITS-1:0] ax, ay, az;
  logic [33:0] mag2;
  logic [31:0] thr2;
  assign ax   = in_accel_x[SAMPLE_BITS-1:0];
  assign ay   = in_accel_y[SAMPLE_BITS-1:0];
  assign az   = in_accel_z[SAMPLE_BITS-1:0];
  assign mag2 = 34'(ax*ax) + 34'(ay*ay) + 34'(az*az);
  assign thr2 = thr_r * thr_r;

  // filter: f' = s + floor(alpha*(f - s) / 2^16)
  function automatic logic signed [FW-1:0] lp(input logic signed [FW-1:0] f,
                                              input logic signed [SAMPLE_BITS-1:0] s,
                                              input logic [15:0] a);
    logic signed [FW-1:0] sv;
    logic signed [FW:0]   d;
    logic signed [FW+17:0] p;
    sv = FW'(s) <<< FILTER_FRAC_BITS;
    d  = (FW+1)'(f) - (FW+1)'(sv);
    p  = (FW+18)'(d) * $signed({2'b0, a});
    lp = sv + FW'(p >>> 16);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_r      <= '0;
      fy_r      <= '0;
      fz_r      <= '0;
      level_r   <= 2'd1;
      changed_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        sx_r <= ax;
        sy_r <= ay;
        sz_r <= az;
        changed_r <= (mag2 >= 34'(thr2));
        if (mag2 >= 34'(thr2))
          level_r <= (level_r == 2'd3) ? 2'd1 : level_r + 2'd1;
      end
      if (cmd.filt) begin
        fx_r <= lp(fx_r, sx_r, alpha_r);
        fy_r <= lp(fy_r, sy_r, alpha_r);
        fz_r <= lp(fz_r, sz_r, alpha_r);
      end
    end
  end

  // CORDIC, one step per cycle
  logic fz_neg;
  logic [4:0] k5;
  assign fz_neg = fz_r[FW-1];
  assign k5     = 5'(k_r);
  assign sts.last_iter = (k_r == KW'(CORDIC_STEPS - 1));

  always_ff @(posedge clk) begin
    if (cmd.cinit) begin
      cx_r  <= fz_neg ? -CW'(fz_r) : CW'(fz_r);
      cy_r  <= fz_neg ? CW'(fy_r) : -CW'(fy_r);
      ang_r <= '0;
      k_r   <= '0;
    end else if (cmd.citer) begin
      if (cy_r > 0) begin
        cx_r  <= cx_r + (cy_r >>> k_r);
        cy_r  <= cy_r - (cx_r >>> k_r);
        ang_r <= ang_r + 27'(atan_q16(k5));
      end else begin
        cx_r  <= cx_r - (cy_r >>> k_r);
        cy_r  <= cy_r + (cx_r >>> k_r);
        ang_r <= ang_r - 27'(atan_q16(k5));
      end
      k_r <= k_r + 1'b1;
    end
  end

  // finish: rounding, clamp, window and LED index
  logic signed [19:0] a8, a8c, roll;
  logic [3:0]  scale;
  logic [6:0]  hw;
  logic signed [19:0] lo, hi, base;
  logic [22:0] num;
  logic [3:0]  q, led;
  logic        inw;
  logic [3:0]  qd;

  always_comb begin
    a8  = 20'((ang_r + 27'sd128) >>> 8);
    a8c = a8;
    if (a8 > 20'sd23040)  a8c = 20'sd23040;
    if (a8 < -20'sd23040) a8c = -20'sd23040;
    roll = fz_neg ? -(a8c + 20'sd23040) : (a8c + 20'sd23040);
    case (level_r)
      2'd1:    begin scale = 4'd2; hw = 7'd45; end
      2'd2:    begin scale = 4'd3; hw = 7'd30; end
      default: begin scale = 4'd6; hw = 7'd15; end
    endcase
    lo   = 20'(90 - hw) <<< 8;
    hi   = 20'(90 + hw) <<< 8;
    base = 20'(hw * (scale - 4'd1)) <<< 8;
    inw  = (fz_r != '0) && (roll >= lo) && (roll < hi);
    num  = 23'(roll - base) * 23'(scale);
    // quotient by 5120 over a range below 9*5120 or so: compare ladder
    qd = 4'd0;
    for (int i = 1; i <= 8; i++)
      if (num >= 23'(i * 5120)) qd = 4'(i);
    q   = qd;
    led = inw ? 4'd8 - q : 4'd0;
    if (fz_r == '0) roll = '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_in_window      <= inw;
      out_led_index      <= led;
      out_decoder_select <= {led[0], led[1], led[2]};
      out_bank_enable    <= inw && !led[3];
      out_level_now      <= level_r;
      out_level_changed  <= changed_r;
      out_roll_angle     <= 17'(roll);
    end
  end
endmodule
`default_nettype wire

[src/tilt_level_led_indicator_unit.sv]
// Tilt level LED indicator: one result per accepted sample; the CORDIC
// loop does one rotation step per cycle. The next sample is taken
// once the previous result has left or is leaving the output register.
`default_nettype none
module tilt_level_led_indicator_unit #(
  parameter int SAMPLE_BITS      = 16,
  parameter int FILTER_FRAC_BITS = 16,
  parameter int CORDIC_STEPS     = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_accel_x,
  input  wire logic [15:0] in_accel_y,
  input  wire logic [15:0] in_accel_z,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_in_window,
  output logic [3:0]       out_led_index,
  output logic [2:0]       out_decoder_select,
  output logic             out_bank_enable,
  output logic [1:0]       out_level_now,
  output logic             out_level_changed,
  output logic signed [16:0] out_roll_angle
);
  import tilt_pkg::*;

  tilt_cmd_t cmd;
  tilt_sts_t sts;

  tilt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  tilt_dp #(
    .SAMPLE_BITS(SAMPLE_BITS), .FILTER_FRAC_BITS(FILTER_FRAC_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_index(cfg_index[0]), .cfg_hi(cfg_index[1]),
    .cfg_data(cfg_data),
    .in_accel_x(in_accel_x), .in_accel_y(in_accel_y), .in_accel_z(in_accel_z),
    .out_in_window(out_in_window), .out_led_index(out_led_index),
    .out_decoder_select(out_decoder_select), .out_bank_enable(out_bank_enable),
    .out_level_now(out_level_now), .out_level_changed(out_level_changed),
    .out_roll_angle(out_roll_angle)
  );
endmodule
`default_nettype wire

[src/tilt_checker.sv]
// Port-level checks for the tilt indicator.
// Attached to tilt_level_led_indicator_unit by bind.
`default_nettype none
module tilt_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_in_window,
  input wire logic [3:0] out_led_index,
  input wire logic       out_bank_enable,
  input wire logic [1:0] out_level_now
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_level_now != 2'd0) else $error("bad level");
  a_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_window |-> out_led_index == 4'd0 && !out_bank_enable)
    else $error("LED lit outside window");
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("second request too soon");
endmodule

bind tilt_level_led_indicator_unit tilt_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_in_window(out_in_window),
  .out_led_index(out_led_index), .out_bank_enable(out_bank_enable),
  .out_level_now(out_level_now)
);
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the tilt level LED indicator unit.
// It predicts each result from the sample history and the register settings.
// Depends on tilt_pkg and tilt_level_led_indicator_unit.
`timescale 1ns / 100ps

module tb_top;
  import tilt_pkg::*;

  typedef struct packed {
    logic               in_window;
    logic [3:0]         led_index;
    logic [2:0]         decoder_select;
    logic               bank_enable;
    logic [1:0]         level_now;
    logic               level_changed;
    logic signed [16:0] roll_angle;
  } tilt_result_t;

  localparam int REG_ALPHA     = 0;
  localparam int REG_THRESHOLD = 1;
  localparam int WATCHDOG_MAX  = 5000;

  class tilt_scoreboard;
    tilt_result_t expected_q[$];
    longint       filt_x, filt_y, filt_z;
    int unsigned  level, alpha, threshold;
    int           mismatches;
    longint       angle_tab[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                    58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                    229, 115};

    function new();
      filt_x = 0; filt_y = 0; filt_z = 0;
      level = 1; alpha = 58982; threshold = 53444;
      mismatches = 0;
    endfunction

    function void write_reg(int idx, logic [15:0] val);
      if (idx == REG_ALPHA) alpha = val;
      else if (idx == REG_THRESHOLD) threshold = val;
    endfunction

    function longint smooth(longint prev, longint samp);
      longint s;
      s = samp <<< 16;
      return s + ((longint'(alpha) * (prev - s)) >>> 16);
    endfunction

    // vectoring CORDIC, angle in degrees Q.8 clamped to +-90
    function longint roll_q8(longint xv, longint yv);
      longint ang, dx, dy;
      ang = 0;
      for (int k = 0; k < 16; k++) begin
        dx = yv >>> k;
        dy = xv >>> k;
        if (yv > 0) begin
          xv += dx; yv -= dy; ang += angle_tab[k];
        end else begin
          xv -= dx; yv += dy; ang -= angle_tab[k];
        end
      end
      ang = (ang + 128) >>> 8;
      if (ang > DEG90_Q8) ang = DEG90_Q8;
      if (ang < -DEG90_Q8) ang = -DEG90_Q8;
      return ang;
    endfunction

    function void note_request(logic signed [15:0] ax, logic signed [15:0] ay,
                               logic signed [15:0] az);
      tilt_result_t r;
      longint       mag2, thr2, roll, a, lo, hi, num, q;
      int unsigned  scale, hw;
      r = '0;
      filt_x = smooth(filt_x, ax);
      filt_y = smooth(filt_y, ay);
      filt_z = smooth(filt_z, az);
      mag2 = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
      thr2 = longint'(threshold) * threshold;
      if (mag2 >= thr2) begin
        level = (level >= 3) ? 1 : level + 1;
        r.level_changed = 1'b1;
      end
      scale = (level == 1) ? 2 : (level == 2) ? 3 : 6;
      hw = 90 / scale;
      roll = 0;
      if (filt_z != 0) begin
        a = (filt_z < 0) ? roll_q8(-filt_z, filt_y) : roll_q8(filt_z, -filt_y);
        a += DEG90_Q8;
        roll = (filt_z < 0) ? -a : a;
        lo = (90 - hw) * 256;
        hi = (90 + hw) * 256;
        if (roll >= lo && roll < hi) begin
          num = (roll - longint'(hw * (scale - 1)) * 256) * scale;
          q = num / 5120;
          if (q > 8) q = 8;
          r.led_index = 4'(8 - q);
          r.in_window = 1'b1;
          r.decoder_select = {r.led_index[0], r.led_index[1], r.led_index[2]};
          r.bank_enable = ~r.led_index[3];
        end
      end
      r.level_now = 2'(level);
      r.roll_angle = roll[16:0];
      expected_q.push_back(r);
    endfunction

    function void check_result(tilt_result_t got);
      tilt_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = expected_q.pop_front();
      if (got.in_window !== want.in_window || got.led_index !== want.led_index ||
          got.decoder_select !== want.decoder_select ||
          got.bank_enable !== want.bank_enable || got.level_now !== want.level_now ||
          got.level_changed !== want.level_changed ||
          got.roll_angle !== want.roll_angle) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [15:0]        in_accel_x = '0, in_accel_y = '0, in_accel_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  tilt_result_t       got;
  tilt_scoreboard     sb = new();
  logic               quiet = 1'b0;
  int                 stall_left = 0;
  int                 idle_cycles = 0;

  always #4 clk = ~clk;

  tilt_level_led_indicator_unit dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_accel_x, .in_accel_y, .in_accel_z,
    .out_valid, .out_stall,
    .out_in_window(got.in_window), .out_led_index(got.led_index),
    .out_decoder_select(got.decoder_select), .out_bank_enable(got.bank_enable),
    .out_level_now(got.level_now), .out_level_changed(got.level_changed),
    .out_roll_angle(got.roll_angle)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(got);
  end

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(int idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= 2'(idx);
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // present one request and hold it until taken; optional gap afterwards
  task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    int gap;
    in_valid <= 1'b1;
    in_accel_x <= x;
    in_accel_y <= y;
    in_accel_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(x, y, z);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic send_random();
    int unsigned kind, mag;
    int          z, y;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      send_sample(16'($urandom), 16'($urandom), 16'($urandom));
    end else if (kind < 16) begin
      // shock: large values on every axis
      send_sample(16'($urandom_range(30000, 32767)) ^ {16{$urandom_range(0, 1) == 1}},
                  16'($urandom_range(30000, 32767)) ^ {16{$urandom_range(0, 1) == 1}},
                  16'($urandom_range(30000, 32767)) ^ {16{$urandom_range(0, 1) == 1}});
    end else begin
      // tilt within about +-45 degrees of level, sometimes upside down
      mag = $urandom_range(1, 32767);
      z = ($urandom_range(0, 7) == 0) ? -int'(mag) : int'(mag);
      y = int'($urandom_range(0, 2 * mag)) - int'(mag);
      send_sample(16'($urandom_range(0, 20000)), 16'(y), 16'(z));
    end
  endtask

  initial begin
    logic [15:0] directed[12][3] = '{
      '{16'h7FFF, 16'h7FFF, 16'h7FFF}, '{16'h8000, 16'h8000, 16'h8000},
      '{16'h0000, 16'h0000, 16'h0000}, '{16'h0000, 16'h0000, 16'd16384},
      '{16'h0000, -16'sd16384, 16'd16384}, '{16'h0000, 16'd16384, 16'd16384},
      '{16'h0000, 16'd3000, 16'd16384}, '{16'h0000, -16'sd3000, 16'd16384},
      '{16'h0000, 16'h0000, -16'sd16384}, '{16'h0000, 16'd16384, 16'h0000},
      '{16'hFFFF, 16'h0001, 16'h7FFF}, '{16'h0001, 16'hFFFF, 16'h8000}};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 1) begin
        write_reg(REG_ALPHA, 16'd0);
        write_reg(REG_THRESHOLD, 16'd0);
        write_reg(2, 16'hFFFF);
        write_reg(3, 16'h1234);
      end else if (ph == 2) begin
        write_reg(REG_ALPHA, 16'hFFFF);
        write_reg(REG_THRESHOLD, 16'd56756);
      end else if (ph > 2) begin
        write_reg(REG_ALPHA, 16'($urandom_range(0, 65535)));
        write_reg(REG_THRESHOLD, 16'($urandom_range(20000, 56756)));
      end
      if (ph == 1) begin
        foreach (directed[i]) send_sample(directed[i][0], directed[i][1], directed[i][2]);
        drain();
        write_reg(REG_THRESHOLD, 16'd53444);
        foreach (directed[i]) send_sample(directed[i][0], directed[i][1], directed[i][2]);
      end
      for (int i = 0; i < 210; i++) begin
        if (ph == 5 && i == 60) quiet = 1'b1;
        if (ph == 3 && i == 100) drain();
        send_random();
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
